/* rtl/core/idle_gap_frame_receiver_unit_macros.svh */
// ----------------------------------------------------------------------------
// Idle-gap frame receiver: assertion macros
// Concurrent property shorthands, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef IDLE_GAP_FRAME_RECEIVER_UNIT_MACROS_SVH
`define IDLE_GAP_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication.
`define IGFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IGFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/igfr_pkg.sv */
// ----------------------------------------------------------------------------
// Idle-gap frame receiver package
// Shared word types, protocol constants and the slave reply builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package igfr_pkg;

  // Default store capacity in bytes (range 11 to 64).
  localparam int FRAME_BYTES_DEF = 16;

  // Only the leading bytes of a frame are ever decoded.
  localparam int DECODE_BYTES    = 11;
  localparam int POLL_MIN_BYTES  = 3;
  localparam int REPLY_BYTES     = 11;
  localparam int REM_W           = $clog2(REPLY_BYTES);

  localparam logic [7:0] SYNC_BYTE = 8'h88;
  localparam logic [7:0] POLL_BYTE = 8'hff;
  localparam logic [7:0] NODE_A    = 8'h01;
  localparam logic [7:0] NODE_B    = 8'h02;

  // Input opcodes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds.
  localparam logic KIND_READING = 1'b0;
  localparam logic KIND_TX      = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROLE_SLAVE   = 2'd0;
  localparam logic [1:0] REG_OWN_NODE_ID  = 2'd1;
  localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  rx_byte;
    logic [31:0] voltage_sample_bits;
    logic [31:0] current_sample_bits;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  source_node;
    logic [31:0] voltage_word;
    logic [31:0] current_word;
    logic [7:0]  tx_byte;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [15:0] wr_data;
  } cfg_wr_t;

  typedef struct packed {
    logic        role_slave;
    logic [7:0]  own_node_id;
    logic [15:0] idle_timeout_ticks;
  } cfg_t;

  // Frame-end event from the tracker to the result stage.
  typedef struct packed {
    logic        hit;
    logic        kind;
    logic [1:0]  node;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [7:0]  node_id;
  } frame_evt_t;

  typedef logic [REPLY_BYTES-1:0][7:0] reply_t;

  // Reply: sync, id, voltage LSB first, current LSB first, sync.
  function automatic reply_t build_reply(logic [7:0] id, logic [31:0] v, logic [31:0] c);
    reply_t rep;
    rep[0]  = SYNC_BYTE;
    rep[1]  = id;
    rep[2]  = v[7:0];
    rep[3]  = v[15:8];
    rep[4]  = v[23:16];
    rep[5]  = v[31:24];
    rep[6]  = c[7:0];
    rep[7]  = c[15:8];
    rep[8]  = c[23:16];
    rep[9]  = c[31:24];
    rep[10] = SYNC_BYTE;
    return rep;
  endfunction

endpackage

/* rtl/core/igfr_stream_if.sv */
// ----------------------------------------------------------------------------
// Idle-gap frame receiver stream interface
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface igfr_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

/* rtl/core/idle_gap_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// Idle-gap frame receiver
// Serial frame receiver that closes frames on line silence and decodes them.
// ----------------------------------------------------------------------------
//
//   channel   dir  payload                                    role
//   in_if     in   opcode, rx_byte, voltage/current samples   byte or timer tick
//   out_if    out  kind, node, voltage/current words, tx,last reading or reply byte
//   cfg_if    in   reg_index, wr_data                         register writes
//
// An input word passes an input register, then one pass of decode logic,
// then the output register. One word per cycle is taken while the output
// drains; a slave reply holds the output register for all eleven of its
// bytes, and a word that closes a frame waits at the input register until
// the previous reading or reply has fully left.
// Reset (rst_n low, synchronous) idles the line and loads register defaults.
// cfg_if is always ready.
//
`timescale 1ns / 1ps

module idle_gap_frame_receiver_unit #(
  parameter int FRAME_BYTES = igfr_pkg::FRAME_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  igfr_stream_if.sink   in_if,
  igfr_stream_if.source out_if,
  igfr_stream_if.sink   cfg_if
);
  import igfr_pkg::*;

  // Configuration registers.
  cfg_t       cfg_r;

  // Input register.
  logic       item_vld_r, item_vld_nxt;
  in_item_t   item_r;

  frame_evt_t evt;
  logic       emit_free;
  logic       adv;
  logic       in_fire;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.role_slave         <= 1'b0;
      cfg_r.own_node_id        <= 8'd1;
      cfg_r.idle_timeout_ticks <= 16'd3;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.data.reg_index)
        REG_ROLE_SLAVE:   cfg_r.role_slave         <= cfg_if.data.wr_data[0];
        REG_OWN_NODE_ID:  cfg_r.own_node_id        <= cfg_if.data.wr_data[7:0];
        REG_IDLE_TIMEOUT: cfg_r.idle_timeout_ticks <= cfg_if.data.wr_data;
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Advance the held word unless it closes a frame while the output is busy.
  always_comb begin
    adv          = item_vld_r && (!evt.hit || emit_free);
    in_fire      = in_if.valid && in_if.ready;
    item_vld_nxt = in_fire || (item_vld_r && !adv);
  end

  assign in_if.ready = !item_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_if.data;
    end
  end

  igfr_frame_track #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .proc  (adv),
    .item  (item_r),
    .cfg   (cfg_r),
    .evt   (evt)
  );

  igfr_reply_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && evt.hit),
    .evt       (evt),
    .emit_free (emit_free),
    .out_if    (out_if)
  );

endmodule

/* rtl/core/igfr_frame_track.sv */
// ----------------------------------------------------------------------------
// Idle-gap frame tracker
// Line state, idle counter, frame store and frame-end decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module igfr_frame_track #(
  parameter int FRAME_BYTES = igfr_pkg::FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  proc,
  input  igfr_pkg::in_item_t    item,
  input  igfr_pkg::cfg_t        cfg,
  output igfr_pkg::frame_evt_t  evt
);
  import igfr_pkg::*;

  localparam int LEN_W = $clog2(FRAME_BYTES + 1);

  logic             busy_r, busy_nxt;
  logic [15:0]      idle_r, idle_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       store_r [DECODE_BYTES];

  logic             is_byte;
  logic [LEN_W-1:0] wr_idx;
  logic             room;
  logic [15:0]      idle_inc;
  logic             expire;
  logic             mst_ok;
  logic             slv_ok;

  always_comb begin
    is_byte  = (item.opcode == OP_BYTE);
    // A byte on an idle line restarts the frame at entry zero.
    wr_idx   = busy_r ? len_r : '0;
    room     = (wr_idx < LEN_W'(FRAME_BYTES));
    idle_inc = (idle_r == 16'hffff) ? idle_r : idle_r + 16'd1;
    expire   = (idle_inc >= cfg.idle_timeout_ticks);

    mst_ok = (len_r >= LEN_W'(DECODE_BYTES)) &&
             (store_r[0] == SYNC_BYTE) && (store_r[10] == SYNC_BYTE) &&
             ((store_r[1] == NODE_A) || (store_r[1] == NODE_B));
    slv_ok = (len_r >= LEN_W'(POLL_MIN_BYTES)) &&
             (store_r[0] == POLL_BYTE) && (store_r[1] == POLL_BYTE) &&
             (store_r[2] == cfg.own_node_id);

    evt.hit     = !is_byte && busy_r && expire && (cfg.role_slave ? slv_ok : mst_ok);
    evt.kind    = cfg.role_slave ? KIND_TX : KIND_READING;
    evt.node    = store_r[1][1:0];
    evt.word_a  = cfg.role_slave ? item.voltage_sample_bits
                                 : {store_r[5], store_r[4], store_r[3], store_r[2]};
    evt.word_b  = cfg.role_slave ? item.current_sample_bits
                                 : {store_r[9], store_r[8], store_r[7], store_r[6]};
    evt.node_id = cfg.own_node_id;

    busy_nxt = busy_r;
    idle_nxt = idle_r;
    len_nxt  = len_r;
    if (proc) begin
      if (is_byte) begin
        busy_nxt = 1'b1;
        idle_nxt = '0;
        len_nxt  = room ? wr_idx + LEN_W'(1) : wr_idx;
      end else if (busy_r) begin
        idle_nxt = idle_inc;
        if (expire) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idle_r <= '0;
      len_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idle_r <= idle_nxt;
      len_r  <= len_nxt;
    end
  end

  // Bytes past the decoded head are counted but not kept.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DECODE_BYTES; i++) begin
      if (proc && is_byte && (wr_idx == LEN_W'(i))) begin
        store_r[i] <= item.rx_byte;
      end
    end
  end

endmodule

/* rtl/core/igfr_reply_emit.sv */
// ----------------------------------------------------------------------------
// Idle-gap frame receiver result stage
// Output register plus the byte queue that streams a slave reply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module igfr_reply_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  igfr_pkg::frame_evt_t evt,
  output logic                 emit_free,
  igfr_stream_if.source        out_if
);
  import igfr_pkg::*;

  logic                         out_vld_r, out_vld_nxt;
  out_item_t                    out_r, out_nxt;
  logic [REPLY_BYTES-2:0][7:0]  q_r, q_nxt;
  logic [REM_W-1:0]             rem_r, rem_nxt;
  logic                         pop;
  reply_t                       rep;

  function automatic out_item_t tx_word(logic [7:0] b, logic lst);
    out_item_t w;
    w.result_kind  = KIND_TX;
    w.source_node  = '0;
    w.voltage_word = '0;
    w.current_word = '0;
    w.tx_byte      = b;
    w.last         = lst;
    return w;
  endfunction

  always_comb begin
    pop       = out_vld_r && out_if.ready;
    emit_free = !out_vld_r || (out_if.ready && (rem_r == '0));
    rep       = build_reply(evt.node_id, evt.word_a, evt.word_b);

    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    q_nxt       = q_r;
    rem_nxt     = rem_r;

    if (pop) begin
      if (rem_r != '0) begin
        // advance to the next queued reply byte
        out_nxt = tx_word(q_r[0], rem_r == REM_W'(1));
        q_nxt   = {8'h00, q_r[REPLY_BYTES-2:1]};
        rem_nxt = rem_r - REM_W'(1);
      end else begin
        out_vld_nxt = 1'b0;
      end
    end

    if (load) begin
      out_vld_nxt = 1'b1;
      if (evt.kind == KIND_READING) begin
        out_nxt.result_kind  = KIND_READING;
        out_nxt.source_node  = evt.node;
        out_nxt.voltage_word = evt.word_a;
        out_nxt.current_word = evt.word_b;
        out_nxt.tx_byte      = '0;
        out_nxt.last         = 1'b1;
      end else begin
        out_nxt = tx_word(rep[0], 1'b0);
        q_nxt   = rep[REPLY_BYTES-1:1];
        rem_nxt = REM_W'(REPLY_BYTES - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      rem_r     <= '0;
    end else begin
      out_vld_r <= out_vld_nxt;
      rem_r     <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    q_r   <= q_nxt;
  end

  assign out_if.valid = out_vld_r;
  assign out_if.data  = out_r;

endmodule

/* rtl/core/igfr_checker.sv */
// ----------------------------------------------------------------------------
// Idle-gap frame receiver checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "idle_gap_frame_receiver_unit_macros.svh"

module igfr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input igfr_pkg::out_item_t out_data
);
  import igfr_pkg::*;

  logic out_fire;
  logic out_stall;
  logic is_read;
  logic is_tx;
  logic read_ok;
  logic tx_ok;
  logic tx_more;

  assign out_fire  = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;
  assign is_read   = out_valid && (out_data.result_kind == KIND_READING);
  assign is_tx     = out_valid && (out_data.result_kind == KIND_TX);
  assign read_ok   = out_data.last &&
                     ((out_data.source_node == 2'd1) || (out_data.source_node == 2'd2));
  assign tx_ok     = (out_data.source_node == 2'd0) && (out_data.voltage_word == 32'd0) &&
                     (out_data.current_word == 32'd0);
  assign tx_more   = out_fire && (out_data.result_kind == KIND_TX) && !out_data.last;

  `IGFR_ASSERT_NXT(a_out_hold, out_stall, out_valid, "result dropped while stalled")
  `IGFR_ASSERT_NXT(a_out_stable, out_stall, $stable(out_data), "result changed while stalled")
  `IGFR_ASSERT_IMP(a_read_single, is_read, read_ok, "bad master reading")
  `IGFR_ASSERT_IMP(a_tx_clean, is_tx, tx_ok, "reply byte carries reading fields")
  `IGFR_ASSERT_NXT(a_tx_burst, tx_more, is_tx, "gap inside slave reply")

endmodule

bind idle_gap_frame_receiver_unit igfr_checker u_igfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Idle-gap frame receiver testbench
// Drives received bytes and timer ticks into the receiver and register writes
// through its config channel. A local model of the line tracker and the frame
// decoder predicts every reading and reply byte. Both handshakes stall at
// random, and each result is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import igfr_pkg::*;

  localparam int STORE_BYTES   = FRAME_BYTES_DEF;
  localparam int SETTLE_CYCLES = 4;     // input and output registers plus margin
  localparam int DRAIN_CYCLES  = 8;
  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int RESULT_GOAL   = 60;
  localparam int PHASE_WORDS   = 25;

  // Index 3 has no register behind it; writes there must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_index;
    logic [15:0] wr_data;
    in_item_t    word;
    logic        typed;    // want below replaces the model's result
    out_item_t   want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  igfr_stream_if #(.payload_t(in_item_t))  in_ch  ();
  igfr_stream_if #(.payload_t(out_item_t)) out_ch ();
  igfr_stream_if #(.payload_t(cfg_wr_t))   cfg_ch ();

  idle_gap_frame_receiver_unit #(.FRAME_BYTES(STORE_BYTES)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the registers and the line tracker.
  cfg_t        rx_regs;
  logic        rx_busy;
  logic [15:0] rx_silence;
  logic [7:0]  rx_store [STORE_BYTES];
  int          rx_len;

  out_item_t   due_results [$];
  out_item_t   head_result;
  stim_row_t   directed_rows [$];
  stim_row_t   row;
  logic [7:0]  long_frame [$];

  int errors;
  int words_taken;
  int results_made;
  int src_gap_pct;
  int sink_gap_pct;
  int quiet_cycles;

  // --------------------------------------------------------------------------
  // Line model: advance the tracker by one accepted word and queue whatever
  // reading or reply bytes the word releases.
  // --------------------------------------------------------------------------
  task automatic predict_line_word(input in_item_t w);
    logic [7:0] reply [REPLY_BYTES];
    out_item_t  r;
    if (w.opcode == OP_BYTE) begin
      // First byte after silence opens a fresh frame.
      if (!rx_busy) begin
        rx_busy = 1'b1;
        rx_len  = 0;
      end
      // Drop bytes once the store is full; they still reset the silence count.
      if (rx_len < STORE_BYTES) begin
        rx_store[rx_len] = w.rx_byte;
        rx_len++;
      end
      rx_silence = '0;
    end else if (rx_busy) begin
      if (rx_silence != 16'hffff) rx_silence++;
      if (rx_silence >= rx_regs.idle_timeout_ticks) begin
        rx_busy = 1'b0;
        if (!rx_regs.role_slave) begin
          // Master: sync, node 1 or 2, eight payload bytes, sync at index 10.
          if (rx_len >= DECODE_BYTES && rx_store[0] == SYNC_BYTE &&
              rx_store[10] == SYNC_BYTE &&
              (rx_store[1] == NODE_A || rx_store[1] == NODE_B)) begin
            r              = '0;
            r.result_kind  = KIND_READING;
            r.source_node  = rx_store[1][1:0];
            r.voltage_word = {rx_store[5], rx_store[4], rx_store[3], rx_store[2]};
            r.current_word = {rx_store[9], rx_store[8], rx_store[7], rx_store[6]};
            r.last         = 1'b1;
            due_results.push_back(r);
          end
        end else if (rx_len >= POLL_MIN_BYTES && rx_store[0] == POLL_BYTE &&
                     rx_store[1] == POLL_BYTE && rx_store[2] == rx_regs.own_node_id) begin
          // Slave: answer with the samples carried by the closing tick.
          reply[0]  = SYNC_BYTE;
          reply[1]  = rx_regs.own_node_id;
          for (int k = 0; k < 4; k++) begin
            reply[2 + k] = w.voltage_sample_bits[8 * k +: 8];
            reply[6 + k] = w.current_sample_bits[8 * k +: 8];
          end
          reply[10] = SYNC_BYTE;
          for (int i = 0; i < REPLY_BYTES; i++) begin
            r             = '0;
            r.result_kind = KIND_TX;
            r.tx_byte     = reply[i];
            r.last        = (i == REPLY_BYTES - 1);
            due_results.push_back(r);
          end
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Input side. Every call starts and ends at a falling edge.
  // --------------------------------------------------------------------------
  task automatic put_word(input in_item_t w, input logic typed, input out_item_t want);
    int queued;
    while ($urandom_range(0, 99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    queued = due_results.size();
    // Ticks on an idle line are ignored and do not count as traffic.
    if (w.opcode == OP_BYTE || rx_busy) words_taken++;
    predict_line_word(w);
    results_made += due_results.size() - queued;
    if (typed) begin
      while (due_results.size() > queued) due_results.delete(due_results.size() - 1);
      due_results.push_back(want);
    end
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    put_word({OP_BYTE, b, 32'($urandom), 32'($urandom)}, 1'b0, '0);
  endtask

  task automatic send_tick();
    put_word({OP_TICK, 8'($urandom), 32'($urandom), 32'($urandom)}, 1'b0, '0);
  endtask

  // Write one register once the block has gone quiet: drop input valid, wait
  // for every owed result, then let the pipeline empty before the write lands.
  task automatic set_register(input logic [1:0] idx, input logic [15:0] value);
    cfg_wr_t w;
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    w.reg_index = idx;
    w.wr_data   = value;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= w;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      REG_ROLE_SLAVE:   rx_regs.role_slave         = value[0];
      REG_OWN_NODE_ID:  rx_regs.own_node_id        = value[7:0];
      REG_IDLE_TIMEOUT: rx_regs.idle_timeout_ticks = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic stim_row_t word_row(input logic op, input logic [7:0] b,
                                         input logic [31:0] v, input logic [31:0] c);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_WORD;
    r.word = {op, b, v, c};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [15:0] value);
    stim_row_t r;
    r           = '0;
    r.kind      = ROW_CFG;
    r.reg_index = idx;
    r.wr_data   = value;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random traffic
  // --------------------------------------------------------------------------
  task automatic random_settings();
    logic [7:0] id;
    case ($urandom_range(0, 6))
      0, 1: set_register(REG_ROLE_SLAVE, 16'($urandom));
      2, 3: begin
        case ($urandom_range(0, 3))
          0:       id = 8'h00;
          1:       id = 8'hff;
          default: id = 8'($urandom);
        endcase
        // Upper bits are junk; only the low byte is the id.
        set_register(REG_OWN_NODE_ID, {8'($urandom), id});
      end
      4, 5: set_register(REG_IDLE_TIMEOUT,
                         ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 5)));
      default: set_register(REG_SPARE, 16'($urandom));
    endcase
  endtask

  // Mostly frames that pass the decoder, with random payload; the rest are
  // corrupted, truncated, shaped for the other role, or plain noise.
  task automatic random_frame();
    logic [7:0] fb [$];
    logic       as_slave;
    int         pick;
    int         extra;
    int         k;
    int         cut;
    pick     = $urandom_range(0, 99);
    as_slave = rx_regs.role_slave;
    if (pick < 85) begin
      if (pick >= 78) as_slave = !as_slave;
      if (as_slave) begin
        fb.push_back(POLL_BYTE);
        fb.push_back(POLL_BYTE);
        fb.push_back(rx_regs.own_node_id);
        extra = $urandom_range(0, 4);
      end else begin
        fb.push_back(SYNC_BYTE);
        fb.push_back($urandom_range(0, 1) ? NODE_B : NODE_A);
        repeat (8) fb.push_back(8'($urandom));
        fb.push_back(SYNC_BYTE);
        // Now and then run past the store capacity.
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      end
      repeat (extra) fb.push_back(8'($urandom));
      if (pick >= 62 && pick < 78) begin
        k = $urandom_range(0, 3);
        if (k == 3) begin
          // Cut the frame below the decodable length.
          cut = $urandom_range(1, as_slave ? POLL_MIN_BYTES - 1 : DECODE_BYTES - 1);
          while (fb.size() > cut) fb.delete(fb.size() - 1);
        end else begin
          // Flip bits in one of the bytes the decoder checks.
          if (!as_slave && k == 2) k = 10;
          fb[k] = fb[k] ^ 8'($urandom_range(1, 255));
        end
      end
    end else begin
      repeat ($urandom_range(0, 19)) fb.push_back(8'($urandom));
    end

    foreach (fb[i]) begin
      send_byte(fb[i]);
      // A short silence that stays under the timeout must not close the frame.
      if (rx_regs.idle_timeout_ticks > 1 && $urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, rx_regs.idle_timeout_ticks - 1)) send_tick();
    end
    // Usually tick until the frame closes; sometimes let the next frame join.
    if ($urandom_range(0, 9) != 0) begin
      while (rx_busy) send_tick();
    end else begin
      send_tick();
    end
    if ($urandom_range(0, 3) == 0) send_tick();
  endtask

  task automatic random_traffic(input int word_goal, input int result_goal);
    int start;
    start = words_taken;
    while (words_taken - start < word_goal || results_made < result_goal) begin
      if ($urandom_range(0, 2) == 0) random_settings();
      random_frame();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random backpressure, in-order compare.
  // --------------------------------------------------------------------------
  always @(negedge clk) out_ch.ready <= ($urandom_range(0, 99) >= sink_gap_pct);

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %h",
                 $time, out_ch.data);
        errors++;
      end else begin
        head_result = due_results.pop_front();
        check_field("result_kind", 32'(head_result.result_kind),
                    32'(out_ch.data.result_kind));
        check_field("source_node", 32'(head_result.source_node),
                    32'(out_ch.data.source_node));
        check_field("voltage_word", head_result.voltage_word, out_ch.data.voltage_word);
        check_field("current_word", head_result.current_word, out_ch.data.current_word);
        check_field("tx_byte", 32'(head_result.tx_byte), 32'(out_ch.data.tx_byte));
        check_field("last", 32'(head_result.last), 32'(out_ch.data.last));
      end
    end
  end

  // Watchdog: end the run when no channel moves a word for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL idle_gap_frame_receiver_unit");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    out_ch.ready  = 1'b0;
    rst_n         = 1'b0;
    errors        = 0;
    words_taken   = 0;
    results_made  = 0;
    src_gap_pct   = 30;
    sink_gap_pct  = 58;

    // Register defaults and an idle line after reset.
    rx_regs.role_slave         = 1'b0;
    rx_regs.own_node_id        = 8'd1;
    rx_regs.idle_timeout_ticks = 16'd3;
    rx_busy    = 1'b0;
    rx_silence = '0;
    rx_len     = 0;
    foreach (rx_store[i]) rx_store[i] = 8'h00;

    // Master frame from node 2 with all-zero voltage and all-ones current,
    // then six trailing bytes: the last one lands past capacity and is dropped.
    long_frame = '{SYNC_BYTE, NODE_B, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'hff, 8'hff, 8'hff, 8'hff, SYNC_BYTE,
                   8'ha5, 8'h5a, 8'h3c, 8'hc3, 8'h01, 8'h7e};

    // Tick on an idle line: nothing happens.
    directed_rows.push_back(word_row(OP_TICK, 8'hff, 32'hffff_ffff, 32'hffff_ffff));
    foreach (long_frame[i])
      directed_rows.push_back(word_row(OP_BYTE, long_frame[i], 32'h0, 32'h0));
    // Default timeout of three ticks closes the frame on the third.
    directed_rows.push_back(word_row(OP_TICK, 8'h00, 32'h0, 32'h0));
    directed_rows.push_back(word_row(OP_TICK, 8'h00, 32'h0, 32'h0));
    row       = word_row(OP_TICK, 8'h00, 32'h0, 32'h0);
    row.typed = 1'b1;
    row.want  = {KIND_READING, 2'(NODE_B), 32'h0000_0000, 32'hffff_ffff, 8'h00, 1'b1};
    directed_rows.push_back(row);
    // Zero timeout: the first busy tick closes. The two-byte frame must not
    // decode even though the store still holds the old sync at index 10.
    directed_rows.push_back(cfg_row(REG_IDLE_TIMEOUT, 16'd0));
    directed_rows.push_back(word_row(OP_BYTE, SYNC_BYTE, 32'h0, 32'h0));
    directed_rows.push_back(word_row(OP_BYTE, NODE_A, 32'h0, 32'h0));
    directed_rows.push_back(word_row(OP_TICK, 8'h00, 32'h0, 32'h0));
    // Slave with the top id: a poll draws an eleven-byte reply.
    directed_rows.push_back(cfg_row(REG_ROLE_SLAVE, 16'h0001));
    directed_rows.push_back(cfg_row(REG_OWN_NODE_ID, 16'h00ff));
    directed_rows.push_back(cfg_row(REG_IDLE_TIMEOUT, 16'h0001));
    directed_rows.push_back(word_row(OP_BYTE, POLL_BYTE, 32'h0, 32'h0));
    directed_rows.push_back(word_row(OP_BYTE, POLL_BYTE, 32'h0, 32'h0));
    directed_rows.push_back(word_row(OP_BYTE, 8'hff, 32'h0, 32'h0));
    directed_rows.push_back(word_row(OP_TICK, 8'h00, 32'hffff_ffff, 32'h0000_0000));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Phase 1: sender idles lightly, receiver heavily.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        set_register(directed_rows[i].reg_index, directed_rows[i].wr_data);
      end else begin
        put_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
      end
    end
    random_traffic(PHASE_WORDS, 0);

    // Phase 2: swap the idle rates.
    src_gap_pct  = 58;
    sink_gap_pct = 30;
    random_traffic(PHASE_WORDS, 0);

    // Phase 3: no idling on either side; keep going until enough results.
    src_gap_pct  = 0;
    sink_gap_pct = 0;
    random_traffic(PHASE_WORDS, RESULT_GOAL);

    // Drain: wait for every owed result, then watch for strays.
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS idle_gap_frame_receiver_unit");
    end else begin
      $display("FAIL idle_gap_frame_receiver_unit");
    end
    $finish;
  end

endmodule

/* idle_gap_frame_receiver_unit.f */
+incdir+rtl/core
rtl/core/igfr_pkg.sv
rtl/core/igfr_stream_if.sv
rtl/core/igfr_frame_track.sv
rtl/core/igfr_reply_emit.sv
rtl/core/idle_gap_frame_receiver_unit.sv
rtl/core/igfr_checker.sv
bench/tb_top.sv
